>>> rtl/uart8n1_pkg.sv
// Shared types and constants for the 8N1 UART transceiver.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package uart8n1_pkg;

  localparam int BIT_PERIOD_W  = 16;
  localparam int HALF_PERIOD_W = 15;
  localparam int RX_TIMER_W    = 17;
  localparam int CNT_W         = 4;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [BIT_PERIOD_W-1:0]  BIT_PERIOD_RST  = 16'd104;
  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 15'd52;

  // frame bit counts: tx idle + start + 8 data + stop count down from ten to zero
  localparam logic [CNT_W-1:0] TX_FRAME_BITS = 4'd10;
  localparam logic [CNT_W-1:0] RX_DATA_BITS  = 4'd8;

  // register word index, taken from paddr[2]
  typedef enum logic {
    REG_BIT_PERIOD  = 1'b0,
    REG_HALF_PERIOD = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       rx_line;
    logic       tx_load;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       tx_accepted;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/uart8n1_if.sv
// Valid/ready channel interfaces for the tick and result items.
// Depends on uart8n1_pkg for the payload structs.
`default_nettype none
interface uart8n1_in_if;
  logic                  valid;
  logic                  ready;
  uart8n1_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface uart8n1_out_if;
  logic                   valid;
  logic                   ready;
  uart8n1_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/uart_8n1_transceiver.sv
// Top level of the timer-driven 8N1 UART transceiver.
// Depends on uart8n1_pkg and the channel interfaces in uart8n1_if.sv.
//
// Usage: every item on in_chan is one timer tick carrying the sampled
// receive line and an optional byte to send. Each tick produces exactly
// one item on out_chan with the transmit line level, busy, load-taken,
// and a received byte when one completes.
// A tick's result is registered into the result buffer as it is taken.
// Throughput: one tick per cycle while in_ready is high; each tick's state
// update is one compare/decrement pass between the state registers.
// The result side has a two-entry buffer (output register plus skid), so
// a tick is still taken in the cycle the consumer first stalls; in_ready
// drops only once both entries are full, and rises again as one drains.
// Reset (synchronous, rst_n low) puts the transmitter idle with the line
// high, the receiver hunting for a start edge, empties the result buffer
// and loads bit_period 104 and half_bit_period 52. The user must write the
// APB port (byte address 0: bit_period, 4: half_bit_period) only while no
// tick is in flight; the block does not enforce this. pready is tied high.
`default_nettype none
module uart_8n1_transceiver (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  uart8n1_in_if.sink                              in_chan,
  uart8n1_out_if.source                           out_chan,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [uart8n1_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [uart8n1_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [uart8n1_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                    pready
);

  localparam int BPW = uart8n1_pkg::BIT_PERIOD_W;
  localparam int HPW = uart8n1_pkg::HALF_PERIOD_W;
  localparam int RTW = uart8n1_pkg::RX_TIMER_W;
  localparam int CW  = uart8n1_pkg::CNT_W;

  // configuration
  logic [BPW-1:0] bit_period_r;
  logic [HPW-1:0] half_period_r;
  logic           cfg_wr;
  uart8n1_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = uart8n1_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= uart8n1_pkg::BIT_PERIOD_RST;
      half_period_r <= uart8n1_pkg::HALF_PERIOD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        uart8n1_pkg::REG_BIT_PERIOD:  bit_period_r  <= pwdata[BPW-1:0];
        uart8n1_pkg::REG_HALF_PERIOD: half_period_r <= pwdata[HPW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      uart8n1_pkg::REG_BIT_PERIOD:
        prdata = {{(uart8n1_pkg::CFG_DATA_W-BPW){1'b0}}, bit_period_r};
      uart8n1_pkg::REG_HALF_PERIOD:
        prdata = {{(uart8n1_pkg::CFG_DATA_W-HPW){1'b0}}, half_period_r};
      default: prdata = '0;
    endcase
  end

  // transceiver state
  logic [9:0]     tx_shift_r,  tx_shift_nxt;
  logic [CW-1:0]  tx_left_r,   tx_left_nxt;
  logic [BPW-1:0] tx_timer_r,  tx_timer_nxt;
  logic           tx_active_r, tx_active_nxt;
  logic           tx_level_r,  tx_level_nxt;
  logic           rx_hunt_r,   rx_hunt_nxt;
  logic [RTW-1:0] rx_timer_r,  rx_timer_nxt;
  logic [7:0]     rx_shift_r,  rx_shift_nxt;
  logic [CW-1:0]  rx_left_r,   rx_left_nxt;
  logic           rx_last_r,   rx_last_nxt;
  logic           tx_acc;
  logic           rx_done;
  logic [7:0]     rx_out;
  logic [CW-1:0]  rx_left_dec;
  uart8n1_pkg::out_item_t res;

  logic push, pop;
  assign push = in_chan.valid && in_chan.ready;
  assign pop  = out_chan.valid && out_chan.ready;

  always_comb begin
    tx_shift_nxt  = tx_shift_r;
    tx_left_nxt   = tx_left_r;
    tx_timer_nxt  = tx_timer_r;
    tx_active_nxt = tx_active_r;
    tx_level_nxt  = tx_level_r;
    tx_acc        = 1'b0;

    // advance the bit timer first, so a load can land as the frame ends
    if (tx_active_r) begin
      if (tx_timer_r <= BPW'(1)) begin
        tx_timer_nxt = bit_period_r;
        if (tx_left_r == uart8n1_pkg::TX_FRAME_BITS) begin
          tx_level_nxt = 1'b1;
          tx_left_nxt  = tx_left_r - CW'(1);
        end else if (tx_left_r != '0) begin
          tx_level_nxt = tx_shift_r[0];
          tx_shift_nxt = {1'b0, tx_shift_r[9:1]};
          tx_left_nxt  = tx_left_r - CW'(1);
        end else begin
          tx_level_nxt  = tx_shift_r[0];
          tx_shift_nxt  = {1'b0, tx_shift_r[9:1]};
          tx_active_nxt = 1'b0;
          tx_left_nxt   = uart8n1_pkg::TX_FRAME_BITS;
        end
      end else begin
        tx_timer_nxt = tx_timer_r - BPW'(1);
      end
    end

    if (in_chan.data.tx_load && !tx_active_nxt) begin
      tx_shift_nxt  = {1'b1, in_chan.data.tx_byte, 1'b0};
      tx_left_nxt   = uart8n1_pkg::TX_FRAME_BITS;
      tx_timer_nxt  = bit_period_r;
      tx_active_nxt = 1'b1;
      tx_acc        = 1'b1;
    end
  end

  assign rx_left_dec = rx_left_r - CW'(1);

  always_comb begin
    rx_hunt_nxt  = rx_hunt_r;
    rx_timer_nxt = rx_timer_r;
    rx_shift_nxt = rx_shift_r;
    rx_left_nxt  = rx_left_r;
    rx_last_nxt  = in_chan.data.rx_line;
    rx_done      = 1'b0;
    rx_out       = '0;

    if (rx_hunt_r) begin
      if (rx_last_r && !in_chan.data.rx_line) begin
        rx_hunt_nxt  = 1'b0;
        rx_timer_nxt = RTW'(bit_period_r) + RTW'(half_period_r);
      end
    end else if (rx_timer_r <= RTW'(1)) begin
      rx_timer_nxt = RTW'(bit_period_r);
      rx_shift_nxt = {in_chan.data.rx_line, rx_shift_r[7:1]};
      rx_left_nxt  = rx_left_dec;
      if (rx_left_dec == '0) begin
        rx_done     = 1'b1;
        rx_out      = rx_shift_nxt;
        rx_left_nxt = uart8n1_pkg::RX_DATA_BITS;
        rx_hunt_nxt = 1'b1;
      end
    end else begin
      rx_timer_nxt = rx_timer_r - RTW'(1);
    end
  end

  always_comb begin
    res.tx_line     = tx_level_nxt;
    res.tx_busy     = tx_active_nxt;
    res.tx_accepted = tx_acc;
    res.rx_valid    = rx_done;
    res.rx_byte     = rx_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r  <= '0;
      tx_left_r   <= uart8n1_pkg::TX_FRAME_BITS;
      tx_timer_r  <= '0;
      tx_active_r <= 1'b0;
      tx_level_r  <= 1'b1;
      rx_hunt_r   <= 1'b1;
      rx_timer_r  <= '0;
      rx_shift_r  <= '0;
      rx_left_r   <= uart8n1_pkg::RX_DATA_BITS;
      rx_last_r   <= 1'b1;
    end else if (push) begin
      tx_shift_r  <= tx_shift_nxt;
      tx_left_r   <= tx_left_nxt;
      tx_timer_r  <= tx_timer_nxt;
      tx_active_r <= tx_active_nxt;
      tx_level_r  <= tx_level_nxt;
      rx_hunt_r   <= rx_hunt_nxt;
      rx_timer_r  <= rx_timer_nxt;
      rx_shift_r  <= rx_shift_nxt;
      rx_left_r   <= rx_left_nxt;
      rx_last_r   <= rx_last_nxt;
    end
  end

  // result buffer: head register plus one skid entry
  logic                   head_v_r, skid_v_r;
  uart8n1_pkg::out_item_t head_r, skid_r;

  assign in_chan.ready  = !skid_v_r;
  assign out_chan.valid = head_v_r;
  assign out_chan.data  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= push;
      end else begin
        head_v_r <= push;
      end
    end else if (push) begin
      if (head_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        head_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        head_r <= skid_r;
        skid_r <= res;
      end else begin
        head_r <= res;
      end
    end else if (push) begin
      if (head_v_r) begin
        skid_r <= res;
      end else begin
        head_r <= res;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/uart8n1_checker.sv
// Port-level checks for uart_8n1_transceiver, attached with bind.
// Depends on uart8n1_pkg for the result item struct.
`default_nettype none
module uart8n1_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire uart8n1_pkg::out_item_t out_data
);

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // an empty buffer always takes a tick
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("tick refused with empty result buffer");

  // a tick taken into an empty buffer shows its result next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result missing one cycle after tick");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind uart_8n1_transceiver uart8n1_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
`default_nettype wire

>>> sim/tb_uart_8n1_transceiver.sv
// Self-checking bench for the timer-driven 8N1 UART transceiver: ticks go in on
// the valid/ready tick channel; line reports are checked against a twin or script.
// Depends on uart8n1_pkg, the channel interfaces and the uart_8n1_transceiver RTL.
`default_nettype none
module tb_uart_8n1_transceiver;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SCRIPT_ROWS     = 24;
  localparam int PHASES          = 6;
  localparam int SQUEEZE_PHASE   = 4;
  localparam int RTW             = uart8n1_pkg::RX_TIMER_W;

  localparam uart8n1_pkg::out_item_t REPORT_NONE    = '0;
  localparam uart8n1_pkg::out_item_t REPORT_IDLE    = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam uart8n1_pkg::out_item_t REPORT_TAKEN   = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
  localparam uart8n1_pkg::out_item_t REPORT_REFUSED = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
  localparam uart8n1_pkg::out_item_t REPORT_RX_ZERO = '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00};

  typedef struct packed {
    logic                   rx_line;
    logic                   tx_load;
    logic [7:0]             tx_byte;
    logic                   pinned;
    uart8n1_pkg::out_item_t report;
  } tick_row_t;

  typedef struct packed {
    logic        level;
    logic [17:0] span;
  } rx_run_t;

  logic                               clk;
  logic                               rst_n;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [uart8n1_pkg::CFG_ADDR_W-1:0] paddr;
  logic [uart8n1_pkg::CFG_DATA_W-1:0] pwdata;
  logic [uart8n1_pkg::CFG_DATA_W-1:0] prdata;
  logic                               pready;

  uart8n1_in_if  tick_ch ();
  uart8n1_out_if report_ch ();

  uart_8n1_transceiver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (tick_ch),
    .out_chan (report_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Directed ticks run at bit period 2, half period 1. The frame sent is 0xFF;
  // the frame received is 0x00 with a high glitch mid frame and a falling
  // edge in the tick that delivers the byte.
  tick_row_t tick_script [SCRIPT_ROWS] = '{
    '{1'b1, 1'b0, 8'h00, 1'b1, REPORT_IDLE},
    '{1'b1, 1'b1, 8'hFF, 1'b1, REPORT_TAKEN},
    '{1'b1, 1'b1, 8'h00, 1'b1, REPORT_REFUSED},
    '{1'b0, 1'b0, 8'h5A, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'hA5, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'hFF, 1'b0, REPORT_NONE},
    '{1'b1, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b1, 8'h80, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b1, 8'h01, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b1, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b0, 1'b0, 8'h00, 1'b1, REPORT_RX_ZERO},
    '{1'b0, 1'b0, 8'h00, 1'b0, REPORT_NONE},
    '{1'b1, 1'b1, 8'h7F, 1'b0, REPORT_NONE},
    '{1'b0, 1'b1, 8'h00, 1'b1, REPORT_TAKEN}
  };

  int phase_bit   [PHASES] = '{3, 2, 6, 5, 4, 65535};
  int phase_half  [PHASES] = '{1, 1, 3, 7, 2, 32767};
  int phase_ticks [PHASES] = '{320, 260, 320, 260, 320, 250};

  uart8n1_pkg::out_item_t due_reports [$];
  rx_run_t                rx_runs [$];

  int cycle_count  = 0;
  int mismatches   = 0;
  int ticks_done   = 0;
  int frames_taken = 0;
  int bytes_heard  = 0;
  int calm_ticks   = 0;
  bit hold_request = 1'b0;

  // twin of the transceiver state, reset values
  logic [uart8n1_pkg::BIT_PERIOD_W-1:0]  tw_bit_period  = uart8n1_pkg::BIT_PERIOD_RST;
  logic [uart8n1_pkg::HALF_PERIOD_W-1:0] tw_half_period = uart8n1_pkg::HALF_PERIOD_RST;
  logic [9:0]                            tw_tx_shift    = '0;
  logic [uart8n1_pkg::CNT_W-1:0]         tw_tx_left     = uart8n1_pkg::TX_FRAME_BITS;
  logic [uart8n1_pkg::BIT_PERIOD_W-1:0]  tw_tx_timer    = '0;
  logic                                  tw_tx_active   = 1'b0;
  logic                                  tw_tx_level    = 1'b1;
  logic                                  tw_rx_hunting  = 1'b1;
  logic [RTW-1:0]                        tw_rx_timer    = '0;
  logic [7:0]                            tw_rx_shift    = '0;
  logic [uart8n1_pkg::CNT_W-1:0]         tw_rx_left     = uart8n1_pkg::RX_DATA_BITS;
  logic                                  tw_rx_last     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still due", cycle_count,
               due_reports.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Advance the twin by one tick and return the line report it produces.
  function automatic uart8n1_pkg::out_item_t uart_twin_tick(
    input uart8n1_pkg::in_item_t t
  );
    uart8n1_pkg::out_item_t r;
    r = '0;
    if (tw_tx_active) begin
      if (tw_tx_timer <= 1) begin
        tw_tx_timer = tw_bit_period;
        if (tw_tx_left == uart8n1_pkg::TX_FRAME_BITS) begin
          tw_tx_level = 1'b1;
          tw_tx_left  = tw_tx_left - 1'b1;
        end else begin
          tw_tx_level = tw_tx_shift[0];
          tw_tx_shift = tw_tx_shift >> 1;
          if (tw_tx_left != 0) begin
            tw_tx_left = tw_tx_left - 1'b1;
          end else begin
            // stop bit: release the transmitter
            tw_tx_active = 1'b0;
            tw_tx_left   = uart8n1_pkg::TX_FRAME_BITS;
          end
        end
      end else begin
        tw_tx_timer = tw_tx_timer - 1'b1;
      end
    end
    if (t.tx_load && !tw_tx_active) begin
      tw_tx_shift   = {1'b1, t.tx_byte, 1'b0};
      tw_tx_left    = uart8n1_pkg::TX_FRAME_BITS;
      tw_tx_timer   = tw_bit_period;
      tw_tx_active  = 1'b1;
      r.tx_accepted = 1'b1;
    end

    if (tw_rx_hunting) begin
      if (tw_rx_last && !t.rx_line) begin
        tw_rx_hunting = 1'b0;
        tw_rx_timer   = RTW'(tw_bit_period) + RTW'(tw_half_period);
      end
    end else if (tw_rx_timer <= 1) begin
      tw_rx_timer = RTW'(tw_bit_period);
      tw_rx_shift = {t.rx_line, tw_rx_shift[7:1]};
      tw_rx_left  = tw_rx_left - 1'b1;
      if (tw_rx_left == 0) begin
        r.rx_valid    = 1'b1;
        r.rx_byte     = tw_rx_shift;
        tw_rx_left    = uart8n1_pkg::RX_DATA_BITS;
        tw_rx_hunting = 1'b1;
      end
    end else begin
      tw_rx_timer = tw_rx_timer - 1'b1;
    end
    tw_rx_last = t.rx_line;

    r.tx_line = tw_tx_level;
    r.tx_busy = tw_tx_active;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
  endtask

  // Offer one tick after a random gap, hold it until taken, then predict.
  task automatic send_tick(input uart8n1_pkg::in_item_t t, input logic pinned,
                           input uart8n1_pkg::out_item_t pinned_report);
    int                     gap;
    int                     pick;
    uart8n1_pkg::out_item_t r;
    if (calm_ticks > 0) begin
      calm_ticks--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        calm_ticks = $urandom_range(30, 120);
        gap = 0;
      end else if (pick < 60) begin
        gap = 0;
      end else if (pick < 94) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
    end
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    @(posedge clk);
    while (tick_ch.ready !== 1'b1) @(posedge clk);
    r = uart_twin_tick(t);
    due_reports.push_back(pinned ? pinned_report : r);
    ticks_done++;
  endtask

  // Write a register, read it back, and mirror it in the twin.
  task automatic program_reg(input uart8n1_pkg::reg_idx_t idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] got;
    string       what;
    mask = (idx == uart8n1_pkg::REG_BIT_PERIOD) ? 32'h0000_FFFF : 32'h0000_7FFF;
    what = (idx == uart8n1_pkg::REG_BIT_PERIOD) ? "bit_period read-back"
                                                : "half_bit_period read-back";
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    // keep psel up: setup of the read-back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (val & mask))
      note_mismatch(what, val & mask, got & mask);
    if (idx == uart8n1_pkg::REG_BIT_PERIOD)
      tw_bit_period = val[uart8n1_pkg::BIT_PERIOD_W-1:0];
    else
      tw_half_period = val[uart8n1_pkg::HALF_PERIOD_W-1:0];
  endtask

  task automatic wait_drained();
    while (due_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin : report_sink
    int stall_left;
    int calm_left;
    int pick;
    stall_left = 0;
    calm_left  = 0;
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        report_ch.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        report_ch.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5)
          calm_left = $urandom_range(40, 160);
        else if (pick < 9)
          stall_left = $urandom_range(12, 50);
        else if (pick < 40)
          stall_left = $urandom_range(1, 3);
        report_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : report_check
    uart8n1_pkg::out_item_t got;
    uart8n1_pkg::out_item_t want;
    if (rst_n === 1'b1 && report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
      got = report_ch.data;
      if (due_reports.size() == 0) begin
        note_mismatch("report with nothing due", 32'h0, 32'(got));
      end else begin
        want = due_reports.pop_front();
        if (got.tx_line !== want.tx_line)
          note_mismatch("tx_line", 32'(want.tx_line), 32'(got.tx_line));
        if (got.tx_busy !== want.tx_busy)
          note_mismatch("tx_busy", 32'(want.tx_busy), 32'(got.tx_busy));
        if (got.tx_accepted !== want.tx_accepted)
          note_mismatch("tx_accepted", 32'(want.tx_accepted), 32'(got.tx_accepted));
        if (got.rx_valid !== want.rx_valid)
          note_mismatch("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
        if (got.rx_byte !== want.rx_byte)
          note_mismatch("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
        if (got.tx_accepted === 1'b1) frames_taken++;
        if (got.rx_valid === 1'b1) bytes_heard++;
      end
    end
  end

  initial begin : stimulus
    uart8n1_pkg::in_item_t t;
    rx_run_t               run;
    logic [9:0]            frame_bits;
    logic                  run_level;
    int                    run_left;
    int                    p;
    int                    i;
    int                    b;
    int                    kind;
    int                    nbits;
    int                    span;
    int                    bp;
    rst_n         <= 1'b0;
    tick_ch.valid <= 1'b0;
    tick_ch.data  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    run_level = 1'b1;
    run_left  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    program_reg(uart8n1_pkg::REG_BIT_PERIOD, 32'd2);
    program_reg(uart8n1_pkg::REG_HALF_PERIOD, 32'd1);
    for (i = 0; i < SCRIPT_ROWS; i++) begin
      t.rx_line = tick_script[i].rx_line;
      t.tx_load = tick_script[i].tx_load;
      t.tx_byte = tick_script[i].tx_byte;
      send_tick(t, tick_script[i].pinned, tick_script[i].report);
    end
    tick_ch.valid <= 1'b0;
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      program_reg(uart8n1_pkg::REG_BIT_PERIOD, 32'(phase_bit[p]));
      program_reg(uart8n1_pkg::REG_HALF_PERIOD, 32'(phase_half[p]));
      bp = phase_bit[p];
      rx_runs.delete();
      run_left = 0;
      if (p == SQUEEZE_PHASE) hold_request = 1'b1;
      for (i = 0; i < phase_ticks[p]; i++) begin
        if (run_left == 0) begin
          if (rx_runs.size() == 0) begin
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
              // noise burst
              repeat ($urandom_range(1, 6))
                rx_runs.push_back('{1'($urandom_range(0, 1)), 18'($urandom_range(1, bp))});
            end else begin
              // serial frame: idle lead, start, data LSB first, stop;
              // cut short on one kind, bit lengths jittered on another
              frame_bits = {1'b1, 8'($urandom), 1'b0};
              nbits = (kind == 7) ? $urandom_range(1, 9) : 10;
              rx_runs.push_back('{1'b1, 18'($urandom_range(1, 2 * bp))});
              for (b = 0; b < nbits; b++) begin
                span = bp;
                if (kind == 8) span = bp + $urandom_range(0, 2) - 1;
                rx_runs.push_back('{frame_bits[b], 18'(span)});
              end
            end
          end
          run       = rx_runs.pop_front();
          run_level = run.level;
          run_left  = run.span;
        end
        t.rx_line = run_level;
        run_left--;
        t.tx_load = ($urandom_range(0, 7) == 0);
        t.tx_byte = 8'($urandom);
        send_tick(t, 1'b0, REPORT_NONE);
      end
      tick_ch.valid <= 1'b0;
      wait_drained();
    end

    repeat (4) @(posedge clk);
    mismatches += due_reports.size();
    $display("%0d ticks over %0d bit-period settings, one long result hold-off",
             ticks_done, PHASES + 1);
    $display("%0d bytes taken for transmit, %0d bytes received, %0d mismatches",
             frames_taken, bytes_heard, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
